/* src/lcdsfw_pkg.sv */
`default_nettype none
package lcdsfw_pkg;

    localparam int FRAME_W = 17;
    localparam int LEN_W   = 5;

    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_RAW   = 2'd1;
    localparam logic [1:0] KIND_DIGIT = 2'd2;

    localparam logic [3:0]       CMD_PREFIX   = 4'b1000;
    localparam logic [2:0]       WRITE_PREFIX = 3'b101;
    localparam logic [7:0]       DOT_SEGMENT  = 8'h08;
    localparam logic [LEN_W-1:0] CMD_LEN      = 5'd12;
    localparam logic [LEN_W-1:0] WRITE_LEN    = 5'd17;
    localparam logic [LEN_W-1:0] NO_LEN       = 5'd0;

    typedef struct packed {
        logic [FRAME_W-1:0] bits;   // first bit to send sits at the MSB
        logic [LEN_W-1:0]   len;    // zero: no frame
    } t_frame;

    function automatic logic [7:0] seg_encode(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0: seg = 8'hD7;
            4'd1: seg = 8'h50;
            4'd2: seg = 8'hB5;
            4'd3: seg = 8'hF1;
            4'd4: seg = 8'h72;
            4'd5: seg = 8'hE3;
            4'd6: seg = 8'hE7;
            4'd7: seg = 8'h51;
            4'd8: seg = 8'hF7;
            4'd9: seg = 8'hF3;
            4'd10: seg = 8'h08;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage
`default_nettype wire

/* src/lcdsfw_encoder.sv */
`default_nettype none
module lcdsfw_encoder
    import lcdsfw_pkg::*;
(
    input  wire logic [1:0] i_kind,
    input  wire logic [5:0] i_address,
    input  wire logic [7:0] i_value,
    input  wire logic [3:0] i_digit,
    input  wire logic       i_dot,
    output t_frame          o_frame
);

    logic [7:0] seg;
    logic [7:0] data;
    logic [7:0] data_rev;

    always_comb begin
        seg = seg_encode(i_digit);
        if (i_kind == KIND_DIGIT) begin
            data = i_dot ? (seg | DOT_SEGMENT) : (seg & ~DOT_SEGMENT);
        end else begin
            data = i_value;
        end
        for (int i = 0; i < 8; i++) begin
            data_rev[7-i] = data[i];
        end
    end

    always_comb begin
        case (i_kind)
            KIND_CMD: begin
                o_frame.bits = {CMD_PREFIX, i_value, 5'b0};
                o_frame.len  = CMD_LEN;
            end
            KIND_RAW, KIND_DIGIT: begin
                o_frame.bits = {WRITE_PREFIX, i_address, data_rev};
                o_frame.len  = WRITE_LEN;
            end
            default: begin
                o_frame.bits = '0;
                o_frame.len  = NO_LEN;
            end
        endcase
    end

endmodule
`default_nettype wire

/* src/lcdsfw_shifter.sv */
`default_nettype none
module lcdsfw_shifter
    import lcdsfw_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_frame_valid,
    input  wire t_frame i_frame,
    output logic        o_frame_take,
    output logic        o_strobe,
    output logic        o_data_bit,
    output logic        o_frame_last
);

    logic [FRAME_W-1:0] r_word, n_word;
    logic [LEN_W-1:0]   r_left, n_left;
    logic               r_strobe, n_strobe;
    logic               r_bit, n_bit;
    logic               r_last, n_last;

    // load when idle or while the final bit goes out
    assign o_frame_take = i_frame_valid && (r_left <= LEN_W'(1));

    always_comb begin
        n_word   = r_word;
        n_left   = r_left;
        n_strobe = 1'b0;
        n_bit    = r_bit;
        n_last   = 1'b0;
        if (r_left != '0) begin
            n_strobe = 1'b1;
            n_bit    = r_word[FRAME_W-1];
            n_last   = (r_left == LEN_W'(1));
            n_word   = {r_word[FRAME_W-2:0], 1'b0};
            n_left   = r_left - LEN_W'(1);
        end
        if (o_frame_take) begin
            n_word = i_frame.bits;
            n_left = i_frame.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_left   <= n_left;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
        r_word <= n_word;
        r_bit  <= n_bit;
    end

    assign o_strobe     = r_strobe;
    assign o_data_bit   = r_bit;
    assign o_frame_last = r_last;

    a_left_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != '0) |=> r_strobe)
        else $error("bit pending but no strobe");

    a_last_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last |-> r_strobe)
        else $error("frame_last without strobe");

    a_no_take_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left > LEN_W'(1)) |-> !o_frame_take)
        else $error("frame loaded over unsent bits");

    a_len_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_take |-> (i_frame.len == CMD_LEN || i_frame.len == WRITE_LEN
                          || i_frame.len == NO_LEN))
        else $error("bad frame length");

endmodule
`default_nettype wire

/* src/lcd_controller_serial_frame_writer_unit.sv */
`default_nettype none
// channel   | handshake             | signals
// request   | i_start, o_busy       | i_kind, i_address, i_value, i_digit, i_dot
// bit out   | o_strobe (no stall)   | o_data_bit, o_frame_last
//
// A transaction is taken when i_start is high and o_busy low; it gives 12 bits
// (command), 17 bits (write) or none (kind 3), one bit per cycle.
// With the shifter idle, the first bit goes from the request register through the
// shifter word register to the registered bit outputs; sustained throughput is set
// by the one-bit-per-cycle shifter.
// A one-deep request register lets the next transaction in while a frame
// shifts out; o_busy is high while that register is full.
// Synchronous active-low reset empties the request register and the shifter.
module lcd_controller_serial_frame_writer_unit
    import lcdsfw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [1:0] i_kind,
    input  wire logic [5:0] i_address,
    input  wire logic [7:0] i_value,
    input  wire logic [3:0] i_digit,
    input  wire logic       i_dot,
    output logic            o_busy,
    output logic            o_strobe,
    output logic            o_data_bit,
    output logic            o_frame_last
);

    logic       r_pend;
    logic [1:0] r_kind;
    logic [5:0] r_address;
    logic [7:0] r_value;
    logic [3:0] r_digit;
    logic       r_dot;
    logic       accept;
    logic       take;
    t_frame     frame;

    assign accept = i_start && !r_pend;
    assign o_busy = r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (accept) begin
            r_pend <= 1'b1;
        end else if (take) begin
            r_pend <= 1'b0;
        end
        if (accept) begin
            r_kind    <= i_kind;
            r_address <= i_address;
            r_value   <= i_value;
            r_digit   <= i_digit;
            r_dot     <= i_dot;
        end
    end

    lcdsfw_encoder u_encoder (
        .i_kind    (r_kind),
        .i_address (r_address),
        .i_value   (r_value),
        .i_digit   (r_digit),
        .i_dot     (r_dot),
        .o_frame   (frame)
    );

    lcdsfw_shifter u_shifter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (r_pend),
        .i_frame       (frame),
        .o_frame_take  (take),
        .o_strobe      (o_strobe),
        .o_data_bit    (o_data_bit),
        .o_frame_last  (o_frame_last)
    );

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_pend)
        else $error("request register not filled");

    a_take_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> !r_pend)
        else $error("request register not emptied");

endmodule
`default_nettype wire

/* tb/sv/lcd_controller_serial_frame_writer_unit_tb.sv */
`timescale 1ns / 1ps
module lcd_controller_serial_frame_writer_unit_tb;
    import lcdsfw_pkg::*;

    localparam logic [1:0] KIND_NONE  = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         RANDOM_ITEMS = 420;

    class frame_bit_checker;
        logic [1:0] pending_bits[$];   // {frame_last, data_bit}
        int errors;

        function new();
            errors = 0;
        endfunction

        function logic [7:0] segment_pattern(input logic [3:0] digit);
            logic [7:0] seg;
            case (digit)
                4'd0:    seg = 8'hD7;
                4'd1:    seg = 8'h50;
                4'd2:    seg = 8'hB5;
                4'd3:    seg = 8'hF1;
                4'd4:    seg = 8'h72;
                4'd5:    seg = 8'hE3;
                4'd6:    seg = 8'hE7;
                4'd7:    seg = 8'h51;
                4'd8:    seg = 8'hF7;
                4'd9:    seg = 8'hF3;
                4'd10:   seg = 8'h08;
                default: seg = 8'h00;
            endcase
            return seg;
        endfunction

        function void add_frame(input logic [1:0] kind, input logic [5:0] address,
                                input logic [7:0] value, input logic [3:0] digit,
                                input logic dot);
            logic [FRAME_W-1:0] frame;
            logic [7:0]         data;
            logic [7:0]         data_rev;
            int                 len;
            frame = '0;
            len = 0;
            data = value;
            if (kind == KIND_CMD) begin
                frame = {CMD_PREFIX, value, 5'b0};
                len = 12;
            end else if (kind == KIND_RAW || kind == KIND_DIGIT) begin
                if (kind == KIND_DIGIT) begin
                    data = segment_pattern(digit);
                    if (dot)
                        data = data | DOT_SEGMENT;
                    else
                        data = data & ~DOT_SEGMENT;
                end
                for (int i = 0; i < 8; i++)
                    data_rev[7-i] = data[i];
                frame = {WRITE_PREFIX, address, data_rev};
                len = 17;
            end
            for (int i = 0; i < len; i++)
                pending_bits.push_back({(i == len - 1), frame[FRAME_W-1-i]});
        endfunction

        function void check_bit(input logic data_bit, input logic frame_last);
            logic [1:0] exp;
            if (pending_bits.size() == 0) begin
                $display("%0t: unexpected bit data_bit=%b frame_last=%b",
                         $time, data_bit, frame_last);
                errors++;
            end else begin
                exp = pending_bits.pop_front();
                if (data_bit !== exp[0]) begin
                    $display("%0t: data_bit expected %b actual %b", $time, exp[0], data_bit);
                    errors++;
                end
                if (frame_last !== exp[1]) begin
                    $display("%0t: frame_last expected %b actual %b",
                             $time, exp[1], frame_last);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pending_bits.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic [1:0] i_kind;
    logic [5:0] i_address;
    logic [7:0] i_value;
    logic [3:0] i_digit;
    logic       i_dot;
    logic       o_busy;
    logic       o_strobe;
    logic       o_data_bit;
    logic       o_frame_last;

    frame_bit_checker sb;
    bit               idle_on;
    int               cycles;

    lcd_controller_serial_frame_writer_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_kind       (i_kind),
        .i_address    (i_address),
        .i_value      (i_value),
        .i_digit      (i_digit),
        .i_dot        (i_dot),
        .o_busy       (o_busy),
        .o_strobe     (o_strobe),
        .o_data_bit   (o_data_bit),
        .o_frame_last (o_frame_last)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** lcd_controller_serial_frame_writer_unit: FAILED **");
            $finish;
        end
    end

    // transaction accept and bit check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy)
                sb.add_frame(i_kind, i_address, i_value, i_digit, i_dot);
            if (o_strobe)
                sb.check_bit(o_data_bit, o_frame_last);
        end
    end

    task automatic send_request(input logic [1:0] kind, input logic [5:0] address,
                                input logic [7:0] value, input logic [3:0] digit,
                                input logic dot);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 99) < 11)
            gap = $urandom_range(1, 6);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_kind    <= kind;
        i_address <= address;
        i_value   <= value;
        i_digit   <= digit;
        i_dot     <= dot;
        do
            @(posedge i_clk);
        while (o_busy);
    endtask

    task automatic send_random();
        logic [1:0] kind;
        kind = ($urandom_range(0, 15) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
        send_request(kind, 6'($urandom), 8'($urandom), 4'($urandom_range(0, 15)),
                     1'($urandom));
    endtask

    initial begin
        sb = new();
        cycles = 0;
        idle_on = 1'b0;
        i_rst_n   <= 1'b0;
        i_start   <= 1'b0;
        i_kind    <= KIND_CMD;
        i_address <= '0;
        i_value   <= '0;
        i_digit   <= '0;
        i_dot     <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, every kind, dot on/off, unused digits, no-frame kind
        send_request(KIND_CMD, 6'h3F, 8'h00, 4'd0, 1'b1);
        send_request(KIND_CMD, 6'h00, 8'hFF, 4'd15, 1'b0);
        send_request(KIND_CMD, 6'h15, 8'h5A, 4'd7, 1'b1);
        send_request(KIND_RAW, 6'h00, 8'h00, 4'd15, 1'b1);
        send_request(KIND_RAW, 6'h3F, 8'hFF, 4'd0, 1'b0);
        send_request(KIND_RAW, 6'h2A, 8'h81, 4'd5, 1'b1);
        for (int d = 0; d <= 10; d++)
            send_request(KIND_DIGIT, 6'(d * 6), 8'hFF, 4'(d), 1'(d % 2));
        send_request(KIND_DIGIT, 6'h3F, 8'h00, 4'd0, 1'b1);
        send_request(KIND_DIGIT, 6'h01, 8'h00, 4'd10, 1'b1);
        send_request(KIND_DIGIT, 6'h20, 8'hA5, 4'd13, 1'b1);
        send_request(KIND_DIGIT, 6'h10, 8'h5A, 4'd15, 1'b0);
        send_request(KIND_NONE, 6'h3F, 8'hFF, 4'd15, 1'b1);
        send_request(KIND_CMD, 6'h00, 8'hC3, 4'd0, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = (n < 150) || (n >= 260);
            send_random();
        end
        i_start <= 1'b0;
        @(posedge i_clk);

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("** lcd_controller_serial_frame_writer_unit: PASSED **");
        else
            $display("** lcd_controller_serial_frame_writer_unit: FAILED **");
        $finish;
    end

endmodule
